// ===== rtl/core/i2a_pkg.sv =====
// Shared types, constants and helpers of the integer-to-ASCII formatter.
package i2a_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int MAX_WIDTH_DEF   = 60;
    localparam int DIGIT_SLOTS_DEF = 32;

    localparam int DIGIT_W = 6;

    localparam logic [5:0] BASE_MIN = 6'd2;
    localparam logic [5:0] BASE_MAX = 6'd36;
    localparam logic [5:0] BASE_OCT = 6'd8;
    localparam logic [5:0] BASE_HEX = 6'd16;
    localparam logic [5:0] DIGIT_WRAP = 6'd36;

    // format flag bit positions
    localparam int FL_ZERO   = 0;
    localparam int FL_SIGNED = 1;
    localparam int FL_PLUS   = 2;
    localparam int FL_SPACE  = 3;
    localparam int FL_LEFT   = 4;
    localparam int FL_PREFIX = 5;
    localparam int FL_LOWER  = 6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SETUP = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    // control of the digit cell row
    typedef struct packed {
        logic load;   // clear cells, take a new magnitude
        logic shift;  // move every digit one cell toward the top
    } chain_ctrl_t;

    // per-item field format
    typedef struct packed {
        logic       has_sign;
        logic [7:0] sign_char;
        logic [1:0] pfx_len;
        logic       zero;
        logic       left;
        logic       lower;
        logic [5:0] width;
    } fmt_t;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d,
                                              input logic lower);
        logic [DIGIT_W-1:0] dd;
        dd = (d >= DIGIT_WRAP) ? d - DIGIT_WRAP : d;
        if (dd < 6'd10) begin
            return CH_ZERO + {2'b00, dd};
        end
        return (lower ? CH_A_LO : CH_A_UP) + {2'b00, dd} - 8'd10;
    endfunction

endpackage

// ===== rtl/core/i2a_digit_cell.sv =====
// One digit cell: doubles its digit plus a carry modulo the base, or shifts.
module i2a_digit_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [5:0]                   base,
    input  i2a_pkg::chain_ctrl_t         ctrl,
    input  logic                         live_init,
    input  logic                         c_in,
    input  logic                         v_in,
    input  logic [i2a_pkg::DIGIT_W-1:0]  d_lo,
    input  logic                         live_lo,
    output logic                         c_out,
    output logic                         v_out,
    output logic [i2a_pkg::DIGIT_W-1:0]  digit,
    output logic                         live
);

    logic [i2a_pkg::DIGIT_W-1:0] digit_reg, digit_next;
    logic                        live_reg, live_next;
    logic                        c_out_reg, c_out_next;
    logic                        v_out_reg, v_out_next;
    logic [i2a_pkg::DIGIT_W:0]   dbl;
    logic                        ge;

    assign dbl = {digit_reg, c_in};
    assign ge  = dbl >= {1'b0, base};

    always_comb begin
        digit_next = digit_reg;
        live_next  = live_reg;
        c_out_next = 1'b0;
        v_out_next = 1'b0;
        if (ctrl.load) begin
            digit_next = '0;
            live_next  = live_init;
        end else if (ctrl.shift) begin
            digit_next = d_lo;
            live_next  = live_lo;
        end else if (v_in) begin
            digit_next = ge ? i2a_pkg::DIGIT_W'(dbl - {1'b0, base})
                            : i2a_pkg::DIGIT_W'(dbl);
            c_out_next = ge;
            v_out_next = 1'b1;
            live_next  = live_reg | c_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg  <= 1'b0;
            c_out_reg <= 1'b0;
            v_out_reg <= 1'b0;
        end else begin
            live_reg  <= live_next;
            c_out_reg <= c_out_next;
            v_out_reg <= v_out_next;
        end
        digit_reg <= digit_next;
    end

    assign c_out = c_out_reg;
    assign v_out = v_out_reg;
    assign digit = digit_reg;
    assign live  = live_reg;

endmodule

// ===== rtl/core/i2a_digit_chain.sv =====
// Row of digit cells fed MSB first from the magnitude, skewed one cell per cycle.
module i2a_digit_chain #(
    parameter int VALUE_BITS  = i2a_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_SLOTS = i2a_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  i2a_pkg::chain_ctrl_t         ctrl,
    input  logic [VALUE_BITS-1:0]        mag,
    input  logic [5:0]                   base,
    output logic [i2a_pkg::DIGIT_W-1:0]  top_digit,
    output logic                         top_live,
    output logic                         conv_done
);

    localparam int FW = $clog2(VALUE_BITS + DIGIT_SLOTS);
    localparam logic [FW-1:0] FEED_END = FW'(VALUE_BITS + DIGIT_SLOTS - 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [FW-1:0]         feed_cnt_reg, feed_cnt_next;
    logic                  feed_v;

    logic                        c_arr    [DIGIT_SLOTS];
    logic                        v_arr    [DIGIT_SLOTS];
    logic [i2a_pkg::DIGIT_W-1:0] dig_arr  [DIGIT_SLOTS];
    logic                        live_arr [DIGIT_SLOTS];

    assign feed_v    = feed_cnt_reg < FW'(VALUE_BITS);
    assign conv_done = feed_cnt_reg == FEED_END;

    always_comb begin
        mag_next      = mag_reg;
        feed_cnt_next = feed_cnt_reg;
        if (ctrl.load) begin
            mag_next      = mag;
            feed_cnt_next = '0;
        end else if (!conv_done) begin
            mag_next      = {mag_reg[VALUE_BITS-2:0], 1'b0};
            feed_cnt_next = feed_cnt_reg + FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feed_cnt_reg <= FEED_END;
        end else begin
            feed_cnt_reg <= feed_cnt_next;
        end
        mag_reg <= mag_next;
    end

    for (genvar i = 0; i < DIGIT_SLOTS; i++) begin : g_cell
        logic                        c_lo;
        logic                        v_lo;
        logic [i2a_pkg::DIGIT_W-1:0] d_lo;
        logic                        l_lo;
        if (i == 0) begin : g_first
            assign c_lo = mag_reg[VALUE_BITS-1];
            assign v_lo = feed_v & ~ctrl.load;
            assign d_lo = '0;
            assign l_lo = 1'b0;
        end else begin : g_rest
            assign c_lo = c_arr[i-1];
            assign v_lo = v_arr[i-1];
            assign d_lo = dig_arr[i-1];
            assign l_lo = live_arr[i-1];
        end
        i2a_digit_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .base      (base),
            .ctrl      (ctrl),
            .live_init (i == 0),
            .c_in      (c_lo),
            .v_in      (v_lo),
            .d_lo      (d_lo),
            .live_lo   (l_lo),
            .c_out     (c_arr[i]),
            .v_out     (v_arr[i]),
            .digit     (dig_arr[i]),
            .live      (live_arr[i])
        );
    end

    assign top_digit = dig_arr[DIGIT_SLOTS-1];
    assign top_live  = live_arr[DIGIT_SLOTS-1];

    // the top cell only steps while bits are still in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        conv_done |=> !v_arr[DIGIT_SLOTS-1])
        else $error("top cell stepped after conversion end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |=> feed_cnt_reg == '0 && !conv_done)
        else $error("feed counter not restarted on load");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |=> live_arr[0] && !top_live || DIGIT_SLOTS == 1)
        else $error("live flags not initialized on load");

endmodule

// ===== rtl/core/i2a_emit.sv =====
// Field layout and character sequencer with the result output register.
module i2a_emit #(
    parameter int MAX_WIDTH   = i2a_pkg::MAX_WIDTH_DEF,
    parameter int DIGIT_SLOTS = i2a_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                setup,
    input  logic                                run,
    input  i2a_pkg::fmt_t                       fmt,
    input  logic [$clog2(DIGIT_SLOTS+1)-1:0]    n_digits,
    input  logic [$clog2(DIGIT_SLOTS+1)-1:0]    prec,
    input  logic [i2a_pkg::DIGIT_W-1:0]         top_digit,
    output logic                                digit_shift,
    output logic                                done,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast
);

    localparam int DW    = $clog2(DIGIT_SLOTS + 1);
    localparam int POS_W = $clog2(64 + DIGIT_SLOTS + 4);

    logic [DW-1:0]    ndig;
    logic [POS_W-1:0] fixed, wid, pad, full, len_c;
    logic [POS_W-1:0] a_c, b_c, c_c, d_c, e_c;

    logic [POS_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg, len_reg;
    logic [POS_W-1:0] k_reg, k_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg;
    logic             m_tlast_reg;

    logic [7:0] ch;
    logic       in_digits;
    logic       go;
    logic       last;

    always_comb begin
        ndig  = (n_digits > prec) ? n_digits : prec;
        fixed = POS_W'(fmt.has_sign) + POS_W'(fmt.pfx_len) + POS_W'(ndig);
        wid   = POS_W'(fmt.width);
        pad   = (wid > fixed) ? wid - fixed : '0;
        full  = fixed + pad;
        len_c = (full > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : full;
        a_c   = (!fmt.zero && !fmt.left) ? pad : '0;
        b_c   = a_c + POS_W'(fmt.has_sign);
        c_c   = b_c + POS_W'(fmt.pfx_len);
        d_c   = c_c + (fmt.zero ? pad : '0) + POS_W'(ndig - n_digits);
        e_c   = d_c + POS_W'(n_digits);
    end

    always_comb begin
        ch        = i2a_pkg::CH_SPACE;
        in_digits = 1'b0;
        if (k_reg < a_reg) begin
            ch = i2a_pkg::CH_SPACE;
        end else if (k_reg < b_reg) begin
            ch = fmt.sign_char;
        end else if (k_reg < c_reg) begin
            if (k_reg == b_reg) begin
                ch = i2a_pkg::CH_ZERO;
            end else begin
                ch = fmt.lower ? i2a_pkg::CH_X_LO : i2a_pkg::CH_X_UP;
            end
        end else if (k_reg < d_reg) begin
            ch = i2a_pkg::CH_ZERO;
        end else if (k_reg < e_reg) begin
            ch        = i2a_pkg::digit_char(top_digit, fmt.lower);
            in_digits = 1'b1;
        end
    end

    assign go          = run & (~m_tvalid_reg | m_tready);
    assign last        = k_reg == len_reg - POS_W'(1);
    assign done        = go & last;
    assign digit_shift = go & in_digits;

    always_comb begin
        k_next        = k_reg;
        m_tvalid_next = m_tvalid_reg;
        if (setup) begin
            k_next = '0;
        end else if (go) begin
            k_next = k_reg + POS_W'(1);
        end
        if (go) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            k_reg        <= '0;
            len_reg      <= POS_W'(1);
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            k_reg        <= k_next;
            if (setup) begin
                len_reg <= len_c;
            end
        end
        if (setup) begin
            a_reg <= a_c;
            b_reg <= b_c;
            c_reg <= c_c;
            d_reg <= d_c;
            e_reg <= e_c;
        end
        if (go) begin
            m_tdata_reg <= ch;
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        setup |=> len_reg != '0 && len_reg <= POS_W'(MAX_WIDTH))
        else $error("field length out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        run |-> k_reg < len_reg)
        else $error("character index ran past field end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> m_tvalid && m_tlast)
        else $error("final character not marked");

endmodule

// ===== rtl/core/integer_to_ascii_formatter_top.sv =====
// Top level of the printf-style integer-to-ASCII formatter.
// Each item is converted by a row of DIGIT_SLOTS digit cells that take the magnitude one bit
// per cycle, MSB first, each cell passing its registered carry to the next. A scan then
// shifts the row until the most significant digit sits in the top cell, a setup state lays
// out the field, and the field is sent one character per cycle while m_tready is high;
// s_tready rises again right after the last character is loaded into the output register.
// An item with a base outside 2 to 36 is accepted and produces no characters.
module integer_to_ascii_formatter_top #(
    parameter int VALUE_BITS  = i2a_pkg::VALUE_BITS_DEF,
    parameter int MAX_WIDTH   = i2a_pkg::MAX_WIDTH_DEF,
    parameter int DIGIT_SLOTS = i2a_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // value, base[5:0], width[5:0], min_digits[5:0], zero fill
    input  logic [((VALUE_BITS + 18 + 7) / 8) * 8-1:0]  s_tdata,
    // format_flags[6:0]
    input  logic [6:0]                                  s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // out_char[7:0]
    output logic [7:0]                                  m_tdata,
    output logic                                        m_tlast
);

    localparam int DW = $clog2(DIGIT_SLOTS + 1);

    i2a_pkg::state_t      state_reg, state_next;
    i2a_pkg::fmt_t        fmt_reg, fmt_next;
    logic [5:0]           base_reg;
    logic [DW-1:0]        prec_reg, prec_next;
    logic [DW-1:0]        n_reg, n_next;
    i2a_pkg::chain_ctrl_t ctrl;

    logic [VALUE_BITS-1:0] v_in, mag;
    logic [5:0]            base_in, width_in, prec_in;
    logic [6:0]            flags;
    logic                  in_fire, base_ok, neg, left;

    logic [i2a_pkg::DIGIT_W-1:0] top_digit;
    logic                        top_live, conv_done;
    logic                        digit_shift, emit_done;

    assign v_in     = s_tdata[VALUE_BITS-1:0];
    assign base_in  = s_tdata[VALUE_BITS+5:VALUE_BITS];
    assign width_in = s_tdata[VALUE_BITS+11:VALUE_BITS+6];
    assign prec_in  = s_tdata[VALUE_BITS+17:VALUE_BITS+12];
    assign flags    = s_tuser;

    assign s_tready = state_reg == i2a_pkg::ST_IDLE;
    assign in_fire  = s_tvalid & s_tready;
    assign base_ok  = base_in >= i2a_pkg::BASE_MIN && base_in <= i2a_pkg::BASE_MAX;
    assign neg      = flags[i2a_pkg::FL_SIGNED] & v_in[VALUE_BITS-1];
    assign mag      = neg ? ~v_in + VALUE_BITS'(1) : v_in;
    assign left     = flags[i2a_pkg::FL_LEFT];

    always_comb begin
        fmt_next           = fmt_reg;
        prec_next          = prec_reg;
        fmt_next.has_sign  = neg | flags[i2a_pkg::FL_PLUS] | flags[i2a_pkg::FL_SPACE];
        fmt_next.sign_char = neg ? i2a_pkg::CH_MINUS
                           : (flags[i2a_pkg::FL_PLUS] ? i2a_pkg::CH_PLUS : i2a_pkg::CH_SPACE);
        fmt_next.pfx_len   = 2'd0;
        if (flags[i2a_pkg::FL_PREFIX]) begin
            if (base_in == i2a_pkg::BASE_HEX) begin
                fmt_next.pfx_len = 2'd2;
            end else if (base_in == i2a_pkg::BASE_OCT) begin
                fmt_next.pfx_len = 2'd1;
            end
        end
        fmt_next.zero  = flags[i2a_pkg::FL_ZERO] & ~left;
        fmt_next.left  = left;
        fmt_next.lower = flags[i2a_pkg::FL_LOWER];
        fmt_next.width = ({1'b0, width_in} > 7'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : width_in;
        prec_next      = ({1'b0, prec_in} > 7'(DIGIT_SLOTS)) ? DW'(DIGIT_SLOTS)
                                                             : DW'(prec_in);
    end

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        ctrl.load  = 1'b0;
        ctrl.shift = digit_shift;
        case (state_reg)
            i2a_pkg::ST_IDLE: begin
                if (in_fire && base_ok) begin
                    ctrl.load  = 1'b1;
                    n_next     = DW'(DIGIT_SLOTS);
                    state_next = i2a_pkg::ST_CONV;
                end
            end
            i2a_pkg::ST_CONV: begin
                if (conv_done) begin
                    state_next = i2a_pkg::ST_SCAN;
                end
            end
            i2a_pkg::ST_SCAN: begin
                if (top_live) begin
                    state_next = i2a_pkg::ST_SETUP;
                end else begin
                    ctrl.shift = 1'b1;
                    n_next     = n_reg - DW'(1);
                end
            end
            i2a_pkg::ST_SETUP: begin
                state_next = i2a_pkg::ST_EMIT;
            end
            i2a_pkg::ST_EMIT: begin
                if (emit_done) begin
                    state_next = i2a_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2a_pkg::ST_IDLE;
            n_reg     <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
        if (ctrl.load) begin
            fmt_reg  <= fmt_next;
            prec_reg <= prec_next;
            base_reg <= base_in;
        end
    end

    i2a_digit_chain #(
        .VALUE_BITS  (VALUE_BITS),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .mag       (mag),
        .base      (ctrl.load ? base_in : base_reg),
        .top_digit (top_digit),
        .top_live  (top_live),
        .conv_done (conv_done)
    );

    i2a_emit #(
        .MAX_WIDTH   (MAX_WIDTH),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .setup       (state_reg == i2a_pkg::ST_SETUP),
        .run         (state_reg == i2a_pkg::ST_EMIT),
        .fmt         (fmt_reg),
        .n_digits    (n_reg),
        .prec        (prec_reg),
        .top_digit   (top_digit),
        .digit_shift (digit_shift),
        .done        (emit_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == i2a_pkg::ST_SCAN |-> n_reg != '0)
        else $error("digit count underflow during scan");

    assert property (@(posedge aclk) disable iff (!aresetn)
        digit_shift |-> top_live)
        else $error("digit emitted from a cell above the number");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !base_ok |=> state_reg == i2a_pkg::ST_IDLE)
        else $error("invalid base started a conversion");

endmodule

// ===== tb/sv/integer_to_ascii_formatter_top_tb.sv =====
// Self-checking testbench for the integer-to-ASCII formatter: directed and random numbers.
module integer_to_ascii_formatter_top_tb;
    import i2a_pkg::*;

    localparam logic [6:0] F_ZERO   = 7'b1 << FL_ZERO;
    localparam logic [6:0] F_SIGNED = 7'b1 << FL_SIGNED;
    localparam logic [6:0] F_PLUS   = 7'b1 << FL_PLUS;
    localparam logic [6:0] F_SPACE  = 7'b1 << FL_SPACE;
    localparam logic [6:0] F_LEFT   = 7'b1 << FL_LEFT;
    localparam logic [6:0] F_PREFIX = 7'b1 << FL_PREFIX;
    localparam logic [6:0] F_LOWER  = 7'b1 << FL_LOWER;

    localparam int RANDOM_NUMBERS = 107;
    localparam int CALM_NUMBERS   = 25;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } field_char_t;

    class field_board;
        field_char_t expected_chars[$];
        field_char_t line[$];
        int          fail_count;

        function void add_char(input logic [7:0] ch);
            field_char_t c;
            c.ch = ch;
            c.last = 1'b0;
            if (line.size() < MAX_WIDTH_DEF) line.push_back(c);
        endfunction

        // works out the field text of one accepted number
        function void note_number(input logic [31:0] value, input logic [5:0] base,
                                  input logic [5:0] wdt, input logic [5:0] mind,
                                  input logic [6:0] flags);
            logic [31:0] mag;
            logic [7:0]  sign_ch;
            logic [5:0]  digs[DIGIT_SLOTS_DEF];
            logic        zero_fill;
            logic        left;
            int          prefix;
            int          prec;
            int          field_w;
            int          n;
            int          pad;
            if (base < BASE_MIN || base > BASE_MAX) return;
            line.delete();
            left = flags[FL_LEFT];
            zero_fill = flags[FL_ZERO] && !left;
            prec = (mind > DIGIT_SLOTS_DEF) ? DIGIT_SLOTS_DEF : mind;
            field_w = (wdt > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : wdt;
            mag = value;
            sign_ch = 8'h00;
            if (flags[FL_SIGNED] && value[31]) begin
                sign_ch = CH_MINUS;
                mag = -value;
            end else if (flags[FL_PLUS]) begin
                sign_ch = CH_PLUS;
            end else if (flags[FL_SPACE]) begin
                sign_ch = CH_SPACE;
            end
            prefix = 0;
            if (flags[FL_PREFIX]) prefix = (base == BASE_HEX) ? 2 : ((base == BASE_OCT) ? 1 : 0);
            n = 0;
            do begin
                digs[n] = 6'(mag % base);
                mag = mag / base;
                n++;
            end while (mag != 0 && n < DIGIT_SLOTS_DEF);
            if (n > prec) prec = n;
            pad = field_w - ((sign_ch != 8'h00) ? 1 : 0) - prefix - prec;
            if (pad < 0) pad = 0;
            if (!zero_fill && !left) repeat (pad) add_char(CH_SPACE);
            if (sign_ch != 8'h00) add_char(sign_ch);
            if (prefix >= 1) add_char(CH_ZERO);
            if (prefix == 2) add_char(flags[FL_LOWER] ? CH_X_LO : CH_X_UP);
            if (zero_fill) repeat (pad) add_char(CH_ZERO);
            repeat (prec - n) add_char(CH_ZERO);
            while (n > 0) begin
                n--;
                if (digs[n] < 10) add_char(CH_ZERO + {2'b00, digs[n]});
                else add_char((flags[FL_LOWER] ? CH_A_LO : CH_A_UP) + {2'b00, digs[n]} - 8'd10);
            end
            if (left) repeat (pad) add_char(CH_SPACE);
            line[line.size() - 1].last = 1'b1;
            foreach (line[i]) expected_chars.push_back(line[i]);
        endfunction

        function void check_char(input logic [7:0] ch, input logic last);
            field_char_t want;
            if (expected_chars.size() == 0) begin
                $error("unexpected char: out_char %h, last %b", ch, last);
                fail_count++;
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch) begin
                $error("out_char mismatch: expected %h, actual %h", want.ch, ch);
                fail_count++;
            end
            if (last !== want.last) begin
                $error("last mismatch: expected %b, actual %b", want.last, last);
                fail_count++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // value[31:0], base[5:0], width[5:0], min_digits[5:0], zero fill
    logic [6:0]  s_tuser;   // format_flags[6:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_char[7:0]
    logic        m_tlast;

    field_board board;
    bit         calm;
    bit         long_hold_done;
    int         chars_seen;
    int         stall_cycles;

    integer_to_ascii_formatter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // starts and ends at a falling edge
    task automatic offer_number(input logic [31:0] value, input logic [5:0] base,
                                input logic [5:0] wdt, input logic [5:0] mind,
                                input logic [6:0] flags);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, mind, wdt, base, value};
        s_tuser  <= flags;
        do @(posedge aclk); while (!s_tready);
        board.note_number(value, base, wdt, mind, flags);
        @(negedge aclk);
    endtask

    task automatic offer_random_number();
        logic [31:0] value;
        logic [5:0]  base;
        logic [5:0]  wdt;
        logic [5:0]  mind;
        int          pick;
        case ($urandom_range(0, 3))
            0: value = $urandom;
            1: value = $urandom_range(0, 1000);
            2: value = -$urandom_range(1, 1000);
            default: begin
                pick = $urandom_range(0, 4);
                value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'h1 : (pick == 2) ? 32'h7FFFFFFF :
                        (pick == 3) ? 32'h80000000 : 32'hFFFFFFFF;
            end
        endcase
        pick = $urandom_range(0, 19);
        if (pick == 0) base = 6'($urandom_range(0, 63));
        else if (pick <= 4) base = BASE_HEX;
        else if (pick <= 7) base = BASE_OCT;
        else if (pick <= 10) base = 6'd10;
        else base = 6'($urandom_range(2, 36));
        wdt = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 16));
        mind = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 10));
        offer_number(value, base, wdt, mind, 7'($urandom_range(0, 127)));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_char(m_tdata, m_tlast);
            chars_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && chars_seen >= 40) begin
                // long hold-off: input side must back up
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        board = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        offer_number(32'd0, 6'd10, 6'd0, 6'd0, 7'd0);
        offer_number(32'hFFFFFFFF, 6'd2, 6'd0, 6'd0, 7'd0);
        offer_number(32'h80000000, 6'd10, 6'd0, 6'd0, F_SIGNED);
        offer_number(32'hFFFFFFFF, 6'd10, 6'd5, 6'd0, F_SIGNED | F_PLUS);
        offer_number(32'd42, 6'd10, 6'd0, 6'd0, F_PLUS);
        offer_number(32'd42, 6'd10, 6'd6, 6'd0, F_SPACE);
        offer_number(32'd255, 6'd16, 6'd0, 6'd0, F_PREFIX | F_LOWER);
        offer_number(32'd255, 6'd16, 6'd10, 6'd0, F_PREFIX | F_ZERO);
        offer_number(32'd8, 6'd8, 6'd0, 6'd0, F_PREFIX);
        offer_number(32'd0, 6'd16, 6'd0, 6'd0, F_PREFIX);
        offer_number(32'd12345, 6'd36, 6'd60, 6'd0, F_LOWER | F_LEFT);
        offer_number(32'hDEADBEEF, 6'd35, 6'd63, 6'd0, 7'd0);
        offer_number(32'd1, 6'd0, 6'd8, 6'd0, 7'd0);
        offer_number(32'd1, 6'd1, 6'd8, 6'd0, 7'd0);
        offer_number(32'd1, 6'd37, 6'd8, 6'd0, 7'd0);
        offer_number(32'd1, 6'd63, 6'd8, 6'd0, 7'd0);
        offer_number(32'd5, 6'd10, 6'd0, 6'd32, 7'd0);
        offer_number(32'd5, 6'd10, 6'd40, 6'd63, F_ZERO);
        offer_number(32'hFFFFFF85, 6'd10, 6'd12, 6'd0, F_ZERO | F_LEFT | F_SIGNED);
        offer_number(32'h80000000, 6'd16, 6'd60, 6'd0, F_ZERO | F_SIGNED | F_PREFIX);
        offer_number(32'hFFFFFFFF, 6'd8, 6'd60, 6'd32, 7'h7F);
        offer_number(32'd7, 6'd3, 6'd4, 6'd2, F_SPACE | F_LEFT);
        offer_number(32'h7FFFFFFF, 6'd10, 6'd0, 6'd0, F_SIGNED | F_SPACE);

        for (int i = 0; i < RANDOM_NUMBERS; i++) begin
            if (i == RANDOM_NUMBERS - CALM_NUMBERS) calm = 1'b1;
            offer_random_number();
        end
        s_tvalid <= 1'b0;

        while (board.expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/i2a_pkg.sv
rtl/core/i2a_digit_cell.sv
rtl/core/i2a_digit_chain.sv
rtl/core/i2a_emit.sv
rtl/core/integer_to_ascii_formatter_top.sv
tb/sv/integer_to_ascii_formatter_top_tb.sv
